// File: hdl/i2a_pkg.sv
// i2a_pkg: word types, kind codes and character constants for the
// integer-to-ASCII formatter. No dependencies.
`default_nettype none
package i2a_pkg;

  localparam int unsigned VALUE_BITS = 32;

  localparam logic [1:0] KIND_SDEC = 2'd0;
  localparam logic [1:0] KIND_UDEC = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;
  localparam logic [1:0] KIND_PTR  = 2'd3;

  localparam logic [3:0] MAX_MIN_DIGITS = 4'd9;
  localparam logic [3:0] PTR_DIGITS     = 4'd8;
  localparam logic [3:0] DEC_BASE       = 4'd10;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [VALUE_BITS-1:0] value;
    logic [3:0]            min_digits;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_word_t;

  // job settings handed from the top level to the emitter
  typedef struct packed {
    logic       neg;
    logic       hex;
    logic [3:0] minw;
  } emit_job_t;

  // converter status
  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } conv_stat_t;

endpackage
`default_nettype wire

// File: hdl/i2a_conv.sv
// i2a_conv: bit-serial binary to digit converter (shift-add-3 for decimal,
// plain shift for hex), one value bit per cycle. Depends on i2a_pkg.
`default_nettype none
module i2a_conv import i2a_pkg::*; #(
  parameter int DIGIT_SLOTS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic                     hex,
  input  wire logic [VALUE_BITS-1:0]    magnitude,
  output conv_stat_t                    stat,
  output logic      [4*DIGIT_SLOTS-1:0] digits
);

  localparam int CW = $clog2(VALUE_BITS);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     hex_r, hex_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0]    sh_r, sh_nxt;
  logic [4*DIGIT_SLOTS-1:0] dig_r, dig_nxt;
  logic [4*DIGIT_SLOTS-1:0] adj;
  logic                     carry;

  always_comb begin
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      if (!hex_r && dig_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = dig_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = dig_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    hex_nxt  = hex_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    dig_nxt  = dig_r;
    carry    = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      ovf_nxt  = 1'b0;
      hex_nxt  = hex;
      cnt_nxt  = '0;
      sh_nxt   = magnitude;
      dig_nxt  = '0;
    end else if (busy_r) begin
      {carry, dig_nxt} = {adj, sh_r[VALUE_BITS-1]};
      ovf_nxt = ovf_r | carry;
      sh_nxt  = sh_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(VALUE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    ovf_r <= ovf_nxt;
    hex_r <= hex_nxt;
    cnt_r <= cnt_nxt;
    sh_r  <= sh_nxt;
    dig_r <= dig_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign digits    = dig_r;

endmodule
`default_nettype wire

// File: hdl/i2a_emit.sv
// i2a_emit: character sequencer; emits the prefix, then scans the digit
// shift register top down, one digit a cycle while the output is free,
// into the output register. Depends on i2a_pkg.
`default_nettype none
module i2a_emit import i2a_pkg::*; #(
  parameter int DIGIT_SLOTS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire emit_job_t                job,
  input  wire logic [4*DIGIT_SLOTS-1:0] digits,
  input  wire logic                     ovf,
  output logic                          done,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output out_word_t                     out_word
);

  localparam int PW = $clog2(DIGIT_SLOTS);

  typedef enum logic [2:0] {E_IDLE, E_MINUS, E_ZERO, E_X, E_SCAN} emit_state_t;

  emit_state_t              state_r, state_nxt;
  emit_job_t                job_r, job_nxt;
  logic [4*DIGIT_SLOTS-1:0] dig_r, dig_nxt;
  logic [PW-1:0]            pos_r, pos_nxt;
  logic                     seen_r, seen_nxt;
  logic                     ov_r, ov_nxt;
  out_word_t                ow_r, ow_nxt;
  logic                     free;
  logic [3:0]               cur;
  logic                     show;
  logic [7:0]               ch;

  assign free = !ov_r || out_ready;
  assign cur  = dig_r[4*DIGIT_SLOTS-1 -: 4];
  assign show = seen_r || (cur != 4'd0) || (pos_r < PW'(job_r.minw)) || (pos_r == '0);
  assign ch   = (cur < DEC_BASE) ? (CHAR_ZERO + {4'd0, cur})
                                 : (CHAR_A + {4'd0, cur} - {4'd0, DEC_BASE});

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    dig_nxt   = dig_r;
    pos_nxt   = pos_r;
    seen_nxt  = seen_r;
    ov_nxt    = ov_r;
    ow_nxt    = ow_r;
    done      = 1'b0;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      E_IDLE: begin
        if (start) begin
          job_nxt  = job;
          dig_nxt  = digits;
          seen_nxt = ovf;
          pos_nxt  = PW'(DIGIT_SLOTS - 1);
          if (job.neg) begin
            state_nxt = E_MINUS;
          end else if (job.hex) begin
            state_nxt = E_ZERO;
          end else begin
            state_nxt = E_SCAN;
          end
        end
      end
      E_MINUS: begin
        if (free) begin
          ov_nxt    = 1'b1;
          ow_nxt    = '{out_char: CHAR_MINUS, last_char: 1'b0};
          state_nxt = E_SCAN;
        end
      end
      E_ZERO: begin
        if (free) begin
          ov_nxt    = 1'b1;
          ow_nxt    = '{out_char: CHAR_ZERO, last_char: 1'b0};
          state_nxt = E_X;
        end
      end
      E_X: begin
        if (free) begin
          ov_nxt    = 1'b1;
          ow_nxt    = '{out_char: CHAR_X, last_char: 1'b0};
          state_nxt = E_SCAN;
        end
      end
      E_SCAN: begin
        if (free) begin
          if (show) begin
            ov_nxt   = 1'b1;
            ow_nxt   = '{out_char: ch, last_char: (pos_r == '0)};
            seen_nxt = 1'b1;
          end
          dig_nxt = dig_r << 4;
          pos_nxt = pos_r - 1'b1;
          if (pos_r == '0) begin
            state_nxt = E_IDLE;
            done      = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    job_r  <= job_nxt;
    dig_r  <= dig_nxt;
    pos_r  <= pos_nxt;
    seen_r <= seen_nxt;
    ow_r   <= ow_nxt;
  end

  assign out_valid = ov_r;
  assign out_word  = ow_r;

endmodule
`default_nettype wire

// File: hdl/integer_to_ascii_formatter_core.sv
// integer_to_ascii_formatter_core: top level; input decode, sign handling
// and sequencing of i2a_conv and i2a_emit. Depends on i2a_pkg.
//
//   channel | ports                          | word
//   input   | in_valid, in_ready, in_word    | in_word_t  (req_type, value, min_digits)
//   output  | out_valid, out_ready, out_word | out_word_t (out_char, last_char)
//
// A number is accepted, then converted one value bit per cycle (through the shift-add-3
// register for decimal), then the prefix of up to two characters is sent and the
// DIGIT_SLOTS digit positions are scanned, one digit per cycle unless the output stalls.
// Output stalls hold the emitter; the next word is taken once the last character
// sits in the output register. Synchronous active-low reset; no clearing pass.
`default_nettype none
module integer_to_ascii_formatter_core import i2a_pkg::*; #(
  parameter int DIGIT_SLOTS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_word,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_word_t     out_word
);

  typedef enum logic [1:0] {T_IDLE, T_CONV, T_EMIT} top_state_t;

  top_state_t               state_r, state_nxt;
  emit_job_t                job_r, job_nxt;
  logic                     accept;
  logic                     neg;
  logic [3:0]               minw;
  logic [VALUE_BITS-1:0]    mag;
  logic                     emit_start;
  logic                     emit_done;
  conv_stat_t               cstat;
  logic [4*DIGIT_SLOTS-1:0] digits;

  assign in_ready = (state_r == T_IDLE);
  assign accept   = in_valid && in_ready;
  assign neg      = (in_word.req_type == KIND_SDEC) && in_word.value[VALUE_BITS-1];
  assign mag      = neg ? (~in_word.value + 1'b1) : in_word.value;

  always_comb begin
    if (in_word.req_type == KIND_PTR) begin
      minw = PTR_DIGITS;
    end else if (in_word.min_digits > MAX_MIN_DIGITS) begin
      minw = MAX_MIN_DIGITS;
    end else begin
      minw = in_word.min_digits;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    emit_start = 1'b0;
    case (state_r)
      T_IDLE: begin
        if (accept) begin
          job_nxt   = '{neg: neg, hex: in_word.req_type[1], minw: minw};
          state_nxt = T_CONV;
        end
      end
      T_CONV: begin
        if (cstat.done) begin
          emit_start = 1'b1;
          state_nxt  = T_EMIT;
        end
      end
      T_EMIT: begin
        if (emit_done) begin
          state_nxt = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    job_r <= job_nxt;
  end

  i2a_conv #(.DIGIT_SLOTS(DIGIT_SLOTS)) u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .hex       (in_word.req_type[1]),
    .magnitude (mag),
    .stat      (cstat),
    .digits    (digits)
  );

  i2a_emit #(.DIGIT_SLOTS(DIGIT_SLOTS)) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (emit_start),
    .job       (job_r),
    .digits    (digits),
    .ovf       (cstat.ovf),
    .done      (emit_done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  a_busy_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    cstat.busy |-> state_r == T_CONV)
    else $error("converter busy outside conversion");

  a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    cstat.done |-> state_r == T_CONV)
    else $error("converter done outside conversion");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> cstat.busy)
    else $error("accepted word did not start conversion");

  a_last_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    emit_done |=> out_valid && out_word.last_char)
    else $error("final character missing from output register");

endmodule
`default_nettype wire

// File: dv/integer_to_ascii_formatter_core_tb.sv
`timescale 1ns / 100ps
// Testbench for integer_to_ascii_formatter_core: directed and random numbers of every kind,
// with the expected character stream checked word by word. Depends on i2a_pkg and the core.
module integer_to_ascii_formatter_core_tb;
  import i2a_pkg::*;

  localparam int DIGIT_SLOTS = 16;
  localparam int RANDOM_NUMBERS = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  class ascii_scoreboard;
    out_word_t expected_chars[$];
    int errors = 0;

    task report(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function void push_char(input logic [7:0] ch, input logic last);
      out_word_t w;
      w.out_char = ch;
      w.last_char = last;
      expected_chars.push_back(w);
    endfunction

    // formatted text of one accepted number
    function void queue_text(input in_word_t w);
      logic [VALUE_BITS-1:0] mag;
      logic [VALUE_BITS-1:0] base;
      logic [3:0] digits[DIGIT_SLOTS];
      logic [3:0] d;
      logic neg;
      int n, pad, minw;
      minw = (w.min_digits > MAX_MIN_DIGITS) ? MAX_MIN_DIGITS : w.min_digits;
      if (w.req_type == KIND_PTR) minw = PTR_DIGITS;
      base = (w.req_type == KIND_HEX || w.req_type == KIND_PTR) ? 16 : DEC_BASE;
      neg = (w.req_type == KIND_SDEC) && w.value[VALUE_BITS-1];
      mag = neg ? -w.value : w.value;
      n = 0;
      do begin
        digits[n] = 4'(mag % base);
        n++;
        mag = mag / base;
      end while (mag != 0 && n < DIGIT_SLOTS);
      pad = (minw > n) ? minw - n : 0;
      if (neg) push_char(CHAR_MINUS, 1'b0);
      if (w.req_type == KIND_HEX || w.req_type == KIND_PTR) begin
        push_char(CHAR_ZERO, 1'b0);
        push_char(CHAR_X, 1'b0);
      end
      repeat (pad) push_char(CHAR_ZERO, 1'b0);
      for (int i = n - 1; i >= 0; i--) begin
        d = digits[i];
        push_char((d < DEC_BASE) ? 8'(CHAR_ZERO + d) : 8'(CHAR_A + d - DEC_BASE), i == 0);
      end
    endfunction

    task check_char(input out_word_t got);
      out_word_t exp_w;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected char 0x%02h last %0b", got.out_char, got.last_char));
      end else begin
        exp_w = expected_chars.pop_front();
        if (got.out_char !== exp_w.out_char)
          report($sformatf("out_char 0x%02h, expected 0x%02h", got.out_char, exp_w.out_char));
        if (got.last_char !== exp_w.last_char)
          report($sformatf("last_char %0b, expected %0b", got.last_char, exp_w.last_char));
      end
    endtask

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_word;
  logic out_valid;
  logic out_ready;
  out_word_t out_word;

  ascii_scoreboard text_sb = new();
  int numbers_accepted = 0;
  int idle_cycles = 0;

  integer_to_ascii_formatter_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit idling_allowed();
    return !(numbers_accepted >= 150 && numbers_accepted < 220);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_number(input logic [1:0] kind, input logic [VALUE_BITS-1:0] value,
                             input logic [3:0] min_digits);
    in_word_t w;
    int gap;
    w.req_type = kind;
    w.value = value;
    w.min_digits = min_digits;
    gap = (idling_allowed() && $urandom_range(0, 99) < 37) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    text_sb.queue_text(w);
    numbers_accepted++;
    @(negedge clk);
  endtask

  function automatic logic [VALUE_BITS-1:0] random_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 20);
      2: return (32'h1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
      default: return -$urandom_range(1, 1000);
    endcase
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_number(KIND_SDEC, 32'h0000_0000, 4'd0);
    send_number(KIND_SDEC, 32'h8000_0000, 4'd0);
    send_number(KIND_SDEC, 32'h7fff_ffff, 4'd0);
    send_number(KIND_SDEC, 32'hffff_ffff, 4'd9);
    send_number(KIND_SDEC, 32'd5, 4'd15);
    send_number(KIND_SDEC, 32'h8000_0000, 4'd15);
    send_number(KIND_UDEC, 32'hffff_ffff, 4'd0);
    send_number(KIND_UDEC, 32'h0000_0000, 4'd9);
    send_number(KIND_UDEC, 32'd1234567, 4'd10);
    send_number(KIND_UDEC, 32'h8000_0000, 4'd1);
    send_number(KIND_HEX, 32'h0000_0000, 4'd0);
    send_number(KIND_HEX, 32'hffff_ffff, 4'd0);
    send_number(KIND_HEX, 32'h00ab_cdef, 4'd9);
    send_number(KIND_HEX, 32'h8000_0000, 4'd15);
    send_number(KIND_PTR, 32'h0000_0000, 4'd0);
    send_number(KIND_PTR, 32'h0000_1234, 4'd15);
    send_number(KIND_PTR, 32'hffff_ffff, 4'd3);

    repeat (RANDOM_NUMBERS)
      send_number(2'($urandom_range(0, 3)), random_value(), 4'($urandom_range(0, 15)));
    in_valid <= 1'b0;

    while (text_sb.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (text_sb.errors == 0 && text_sb.pending() == 0) begin
      $display("PASS integer_to_ascii_formatter_core");
    end else begin
      $display("FAIL integer_to_ascii_formatter_core");
    end
    $finish;
  end

  // receiver: random stalls, plus one long hold-off while the sender keeps offering
  initial begin
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && numbers_accepted >= 100) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= !(idling_allowed() && $urandom_range(0, 99) < 37);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) text_sb.check_char(out_word);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL integer_to_ascii_formatter_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
